>>> hdl/cso_pkg.sv
// ----------------------------------------------------------------------------
// cso_pkg
// Shared codes and constants for the circle/shape overlap test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cso_pkg;

	// shape kind carried in req_type
	localparam logic REQ_CIRCLE  = 1'b0;
	localparam logic REQ_SEGMENT = 1'b1;

	// register stages from input to output, output register included
	localparam int PIPE_DEPTH = 7;

endpackage : cso_pkg

`default_nettype wire

>>> hdl/cso_ifs.sv
// ----------------------------------------------------------------------------
// cso_req_if / cso_rsp_if
// Valid/ready channels for query items and overlap results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cso_req_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic        [COORD_BITS-2:0] query_radius;
	logic signed [COORD_BITS-1:0] shape_ax;
	logic signed [COORD_BITS-1:0] shape_ay;
	logic signed [COORD_BITS-1:0] shape_bx;
	logic signed [COORD_BITS-1:0] shape_by;
	logic        [COORD_BITS-2:0] shape_radius;

	modport source (
		output valid, req_type, query_x, query_y, query_radius,
		       shape_ax, shape_ay, shape_bx, shape_by, shape_radius,
		input  ready
	);
	modport sink (
		input  valid, req_type, query_x, query_y, query_radius,
		       shape_ax, shape_ay, shape_bx, shape_by, shape_radius,
		output ready
	);
endinterface : cso_req_if

interface cso_rsp_if;
	logic valid;
	logic ready;
	logic overlaps;

	modport source (output valid, overlaps, input ready);
	modport sink (input valid, overlaps, output ready);
endinterface : cso_rsp_if

`default_nettype wire

>>> hdl/circle_shape_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// circle_shape_overlap_test_unit
// Query circle against a circle or a line segment, exact squared-form test.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | handshake
//  req     | in  | req_type, query xy/radius, shape a, b, radius | valid/ready
//  rsp     | out | overlaps                                      | valid/ready
//
//  One item per cycle sustained while the output is not stalled; seven
//  register stages: differences, squares/products, sums, compares, split
//  products for the distance test, recombine, final compare to output register.
//  arst_n clears the valid bits only; no clearing pass is needed.
//  Each stage holds under backpressure and fills its bubbles, so a stalled
//  output keeps taking items until every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_shape_overlap_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	cso_req_if.sink    req,
	cso_rsp_if.source  rsp
);
	import cso_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;        // coordinate difference
	localparam int P  = 2 * C + 2;    // product / sum of squares
	localparam int Q  = P + 1;        // signed dot and cross
	localparam int K  = C + 1;        // split point of wide operands
	localparam int R  = 2 * C;        // squared radius
	localparam int RH = R + K;        // squared radius times half of den
	localparam int W  = 2 * P;        // final compare width

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7 = !vld_s7 || rsp.ready;
	assign rdy6 = !vld_s6 || rdy7;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign req.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= req.valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
			if (rdy7) vld_s7 <= vld_s6;
		end
	end

	// ---- stage 1: differences, radius select
	logic                seg_s1;
	logic signed [D-1:0] wx_s1, wy_s1, dx_s1, dy_s1, ex_s1, ey_s1;
	logic        [C-1:0] r_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			seg_s1 <= (req.req_type == REQ_SEGMENT);
			wx_s1  <= D'(req.query_x)  - D'(req.shape_ax);
			wy_s1  <= D'(req.query_y)  - D'(req.shape_ay);
			dx_s1  <= D'(req.shape_bx) - D'(req.shape_ax);
			dy_s1  <= D'(req.shape_by) - D'(req.shape_ay);
			ex_s1  <= D'(req.query_x)  - D'(req.shape_bx);
			ey_s1  <= D'(req.query_y)  - D'(req.shape_by);
			if (req.req_type == REQ_SEGMENT) begin
				r_s1 <= C'(req.query_radius);
			end else begin
				r_s1 <= C'(req.query_radius) + C'(req.shape_radius);
			end
		end
	end

	// ---- stage 2: products
	logic                seg_s2;
	logic signed [P-1:0] wxx_s2, wyy_s2, exx_s2, eyy_s2, dxx_s2, dyy_s2;
	logic signed [P-1:0] dxwx_s2, dywy_s2, dxwy_s2, dywx_s2;
	logic        [R-1:0] rr_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && vld_s1) begin
			seg_s2  <= seg_s1;
			wxx_s2  <= P'(wx_s1) * P'(wx_s1);
			wyy_s2  <= P'(wy_s1) * P'(wy_s1);
			exx_s2  <= P'(ex_s1) * P'(ex_s1);
			eyy_s2  <= P'(ey_s1) * P'(ey_s1);
			dxx_s2  <= P'(dx_s1) * P'(dx_s1);
			dyy_s2  <= P'(dy_s1) * P'(dy_s1);
			dxwx_s2 <= P'(dx_s1) * P'(wx_s1);
			dywy_s2 <= P'(dy_s1) * P'(wy_s1);
			dxwy_s2 <= P'(dx_s1) * P'(wy_s1);
			dywx_s2 <= P'(dy_s1) * P'(wx_s1);
			rr_s2   <= R'(r_s1) * R'(r_s1);
		end
	end

	// ---- stage 3: sums of products
	logic                seg_s3;
	logic        [P-1:0] d2a_s3, d2b_s3, den_s3;
	logic signed [Q-1:0] tn_s3, cr_s3;
	logic        [R-1:0] rr_s3;

	// squares are non-negative and their sums fit P bits unsigned
	always_ff @(posedge clk) begin
		if (rdy3 && vld_s2) begin
			seg_s3 <= seg_s2;
			d2a_s3 <= $unsigned(wxx_s2) + $unsigned(wyy_s2);
			d2b_s3 <= $unsigned(exx_s2) + $unsigned(eyy_s2);
			den_s3 <= $unsigned(dxx_s2) + $unsigned(dyy_s2);
			tn_s3  <= Q'(dxwx_s2) + Q'(dywy_s2);
			cr_s3  <= Q'(dxwy_s2) - Q'(dywx_s2);
			rr_s3  <= rr_s2;
		end
	end

	// ---- stage 4: endpoint decisions, cross magnitude
	logic         done_s4, early_s4;
	logic [P-1:0] crm_s4, den_s4;
	logic [R-1:0] rr_s4;
	logic         tn_le0, den_le_tn, a_hit, b_hit;
	logic [Q-1:0] cr_abs;

	always_comb begin
		tn_le0    = tn_s3[Q-1] || (tn_s3 == '0);
		den_le_tn = $signed({1'b0, den_s3}) <= tn_s3;
		a_hit     = d2a_s3 <= P'(rr_s3);
		b_hit     = d2b_s3 <= P'(rr_s3);
		cr_abs    = cr_s3[Q-1] ? $unsigned(-cr_s3) : $unsigned(cr_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy4 && vld_s3) begin
			// circle, or projection clamped to an endpoint: answer known here
			done_s4  <= !seg_s3 || tn_le0 || den_le_tn;
			early_s4 <= (!seg_s3 || tn_le0) ? a_hit : b_hit;
			crm_s4   <= cr_abs[P-1:0];
			den_s4   <= den_s3;
			rr_s4    <= rr_s3;
		end
	end

	// ---- stage 5: split products for cross^2 <= rr * den
	logic            done_s5, early_s5;
	logic [2*K-1:0]  hh_s5, hl_s5, ll_s5;
	logic [RH-1:0]   rh_s5, rl_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			done_s5  <= done_s4;
			early_s5 <= early_s4;
			hh_s5    <= (2*K)'(crm_s4[P-1:K]) * (2*K)'(crm_s4[P-1:K]);
			hl_s5    <= (2*K)'(crm_s4[P-1:K]) * (2*K)'(crm_s4[K-1:0]);
			ll_s5    <= (2*K)'(crm_s4[K-1:0]) * (2*K)'(crm_s4[K-1:0]);
			rh_s5    <= RH'(rr_s4) * RH'(den_s4[P-1:K]);
			rl_s5    <= RH'(rr_s4) * RH'(den_s4[K-1:0]);
		end
	end

	// ---- stage 6: recombine
	logic         done_s6, early_s6;
	logic [W-1:0] cr2_s6, rd_s6;

	always_ff @(posedge clk) begin
		if (rdy6 && vld_s5) begin
			done_s6  <= done_s5;
			early_s6 <= early_s5;
			cr2_s6   <= (W'(hh_s5) << (2 * K)) + (W'(hl_s5) << (K + 1)) + W'(ll_s5);
			rd_s6    <= (W'(rh_s5) << K) + W'(rl_s5);
		end
	end

	// ---- stage 7: output register
	logic ovl_s7;

	always_ff @(posedge clk) begin
		if (rdy7 && vld_s6) begin
			ovl_s7 <= done_s6 ? early_s6 : (cr2_s6 <= rd_s6);
		end
	end

	assign rsp.valid    = vld_s7;
	assign rsp.overlaps = ovl_s7;

endmodule : circle_shape_overlap_test_unit

`default_nettype wire

>>> hdl/cso_checker.sv
// ----------------------------------------------------------------------------
// cso_checker
// Port-level checks on item flow through the overlap test unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_checker (
	input wire clk,
	input wire arst_n,
	input wire req_valid,
	input wire req_ready,
	input wire rsp_valid,
	input wire rsp_ready
);
	import cso_pkg::*;

	localparam int CW = $clog2(PIPE_DEPTH + 1);

	logic [CW-1:0] inflight_q;
	logic          in_acc, out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// never more items inside than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	// no result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != '0)
		else $error("result shown with no item in flight");

	// an empty output stage means the input side can take an item
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled while output stage is empty");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

endmodule : cso_checker

bind circle_shape_overlap_test_unit cso_checker u_cso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready)
);

`default_nettype wire

>>> dv/tb_circle_shape_overlap_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_shape_overlap_test_unit
// Streams circle and segment queries through the overlap unit and checks
// every result against an exact wide-integer predictor, in order. Runs a
// directed set of boundary cases, then random phases with source gaps and
// sink stalls, plus a long sink hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------

module tb_circle_shape_overlap_test_unit;
	import cso_pkg::*;

	localparam int COORD_BITS = 16;

	typedef logic signed [127:0] acc_t;

	typedef struct {
		logic                         req_type;
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
		logic        [COORD_BITS-2:0] query_radius;
		logic signed [COORD_BITS-1:0] shape_ax;
		logic signed [COORD_BITS-1:0] shape_ay;
		logic signed [COORD_BITS-1:0] shape_bx;
		logic signed [COORD_BITS-1:0] shape_by;
		logic        [COORD_BITS-2:0] shape_radius;
	} query_item_t;

	logic clk;
	logic arst_n;

	cso_req_if #(.COORD_BITS(COORD_BITS)) req ();
	cso_rsp_if rsp ();

	circle_shape_overlap_test_unit #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	query_item_t query_pending_q[$];
	logic        overlap_expect_q[$];
	query_item_t cur_query;
	int          src_idle_pct  = 0;
	int          snk_stall_pct = 0;
	logic        sink_hold     = 1'b0;
	int          mismatch_cnt  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("FAIL circle_shape_overlap_test_unit");
		$finish;
	end

	function automatic acc_t sq_dist(acc_t px, acc_t py, acc_t qx, acc_t qy);
		return (px - qx) * (px - qx) + (py - qy) * (py - qy);
	endfunction

	// exact squared-form test, no rounding anywhere
	function automatic logic overlap_predict(query_item_t it);
		acc_t qx, qy, qr, ax, ay, bx, by, sr;
		acc_t dx, dy, wx, wy, rr, tn, den, cr;
		qx = acc_t'(it.query_x);
		qy = acc_t'(it.query_y);
		qr = acc_t'(it.query_radius);
		ax = acc_t'(it.shape_ax);
		ay = acc_t'(it.shape_ay);
		bx = acc_t'(it.shape_bx);
		by = acc_t'(it.shape_by);
		sr = acc_t'(it.shape_radius);
		if (it.req_type == REQ_CIRCLE)
			return sq_dist(qx, qy, ax, ay) <= (qr + sr) * (qr + sr);
		dx  = bx - ax;
		dy  = by - ay;
		wx  = qx - ax;
		wy  = qy - ay;
		rr  = qr * qr;
		tn  = wx * dx + wy * dy;
		den = dx * dx + dy * dy;
		// clamp to start (also covers zero-length), then to end
		if (tn <= 0)
			return sq_dist(qx, qy, ax, ay) <= rr;
		if (den <= tn)
			return sq_dist(qx, qy, bx, by) <= rr;
		cr = dx * wy - dy * wx;
		return cr * cr <= rr * den;
	endfunction

	function automatic query_item_t mk_query(logic kind, int qx, int qy, int qr,
	                                         int ax, int ay, int bx, int by, int sr);
		query_item_t it;
		it.req_type     = kind;
		it.query_x      = COORD_BITS'(qx);
		it.query_y      = COORD_BITS'(qy);
		it.query_radius = (COORD_BITS-1)'(qr);
		it.shape_ax     = COORD_BITS'(ax);
		it.shape_ay     = COORD_BITS'(ay);
		it.shape_bx     = COORD_BITS'(bx);
		it.shape_by     = COORD_BITS'(by);
		it.shape_radius = (COORD_BITS-1)'(sr);
		return it;
	endfunction

	function automatic void queue_query(query_item_t it);
		query_pending_q = {query_pending_q, it};
	endfunction

	function automatic int rand_int(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic query_item_t random_query();
		query_item_t it;
		int mode, k, delta, s1, s2, d, qx, qy;
		logic horiz;
		it.req_type     = 1'($urandom_range(1));
		it.query_x      = COORD_BITS'($urandom());
		it.query_y      = COORD_BITS'($urandom());
		it.query_radius = (COORD_BITS-1)'($urandom());
		it.shape_ax     = COORD_BITS'($urandom());
		it.shape_ay     = COORD_BITS'($urandom());
		it.shape_bx     = COORD_BITS'($urandom());
		it.shape_by     = COORD_BITS'($urandom());
		it.shape_radius = (COORD_BITS-1)'($urandom());
		mode = $urandom_range(9);
		if (mode < 3)
			return it;
		if (mode < 6) begin
			// tight box: endpoints, clamping and touching show up often
			it.query_x      = COORD_BITS'(rand_int(-40, 40));
			it.query_y      = COORD_BITS'(rand_int(-40, 40));
			it.query_radius = (COORD_BITS-1)'($urandom_range(40));
			it.shape_ax     = COORD_BITS'(rand_int(-40, 40));
			it.shape_ay     = COORD_BITS'(rand_int(-40, 40));
			it.shape_bx     = COORD_BITS'(rand_int(-40, 40));
			it.shape_by     = COORD_BITS'(rand_int(-40, 40));
			it.shape_radius = (COORD_BITS-1)'($urandom_range(40));
			return it;
		end
		// built right at the touching distance, off by at most one
		qx    = rand_int(-8000, 8000);
		qy    = rand_int(-8000, 8000);
		k     = rand_int(1, 1000);
		delta = rand_int(-1, 1);
		it.query_x = COORD_BITS'(qx);
		it.query_y = COORD_BITS'(qy);
		if (it.req_type == REQ_CIRCLE) begin
			it.shape_ax     = COORD_BITS'(qx + ($urandom_range(1) ? 3 * k : -3 * k));
			it.shape_ay     = COORD_BITS'(qy + ($urandom_range(1) ? 4 * k : -4 * k));
			s1              = rand_int(0, 5 * k + delta);
			it.query_radius = (COORD_BITS-1)'(s1);
			it.shape_radius = (COORD_BITS-1)'(5 * k + delta - s1);
		end else begin
			s1    = rand_int(-4000, 4000);
			s2    = rand_int(-4000, 4000);
			d     = $urandom_range(1) ? k : -k;
			horiz = 1'($urandom_range(1));
			it.shape_ax     = COORD_BITS'(horiz ? qx + s1 : qx + d);
			it.shape_ay     = COORD_BITS'(horiz ? qy + d : qy + s1);
			it.shape_bx     = COORD_BITS'(horiz ? qx + s2 : qx + d);
			it.shape_by     = COORD_BITS'(horiz ? qy + d : qy + s2);
			it.query_radius = (COORD_BITS-1)'(k + delta);
		end
		return it;
	endfunction

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid        <= 1'b0;
			req.req_type     <= REQ_CIRCLE;
			req.query_x      <= '0;
			req.query_y      <= '0;
			req.query_radius <= '0;
			req.shape_ax     <= '0;
			req.shape_ay     <= '0;
			req.shape_bx     <= '0;
			req.shape_by     <= '0;
			req.shape_radius <= '0;
		end else begin
			if (req.valid && req.ready)
				overlap_expect_q = {overlap_expect_q, overlap_predict(cur_query)};
			if (!req.valid || req.ready) begin
				if (query_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_query = query_pending_q.pop_front();
					req.valid        <= 1'b1;
					req.req_type     <= cur_query.req_type;
					req.query_x      <= cur_query.query_x;
					req.query_y      <= cur_query.query_y;
					req.query_radius <= cur_query.query_radius;
					req.shape_ax     <= cur_query.shape_ax;
					req.shape_ay     <= cur_query.shape_ay;
					req.shape_bx     <= cur_query.shape_bx;
					req.shape_by     <= cur_query.shape_by;
					req.shape_radius <= cur_query.shape_radius;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// sink side and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin : chk
				logic expected_hit;
				if (overlap_expect_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual overlaps=%b",
					         $time, rsp.overlaps);
					mismatch_cnt++;
				end else begin
					expected_hit = overlap_expect_q.pop_front();
					if (rsp.overlaps !== expected_hit) begin
						$display("%0t: overlaps mismatch, expected %b, actual %b",
						         $time, expected_hit, rsp.overlaps);
						mismatch_cnt++;
					end
				end
			end
			rsp.ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic wait_results();
		while (query_pending_q.size() != 0 || req.valid || overlap_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int n, int src_pct, int snk_pct);
		int i;
		@(negedge clk);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		for (i = 0; i < n; i++)
			queue_query(random_query());
		wait_results();
	endtask

	initial begin
		int i;
		// edge at time 0 after every process is waiting
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// circle: touching, apart, point circles, full-range extremes
		queue_query(mk_query(REQ_CIRCLE, 0, 0, 2, 3, 4, 0, 0, 3));
		queue_query(mk_query(REQ_CIRCLE, 0, 0, 2, 3, 5, 0, 0, 3));
		queue_query(mk_query(REQ_CIRCLE, 100, -100, 0, 100, -100, 0, 0, 0));
		queue_query(mk_query(REQ_CIRCLE, 100, -100, 0, 101, -100, 0, 0, 0));
		queue_query(mk_query(REQ_CIRCLE, -32768, -32768, 32767,
		                     32767, 32767, -32768, 32767, 32767));
		queue_query(mk_query(REQ_CIRCLE, 32767, -32768, 32767,
		                     32767, -32768, 32767, -32768, 32767));
		queue_query(mk_query(REQ_CIRCLE, -32768, 0, 32767,
		                     32766, 0, 0, 0, 32767));
		// segment: interior touch/miss, before start, past end
		queue_query(mk_query(REQ_SEGMENT, 5, 3, 3, 0, 0, 10, 0, 32767));
		queue_query(mk_query(REQ_SEGMENT, 5, 3, 2, 0, 0, 10, 0, 0));
		queue_query(mk_query(REQ_SEGMENT, -3, 4, 5, 0, 0, 10, 0, 0));
		queue_query(mk_query(REQ_SEGMENT, -3, 4, 4, 0, 0, 10, 0, 0));
		queue_query(mk_query(REQ_SEGMENT, 13, 4, 5, 0, 0, 10, 0, 0));
		queue_query(mk_query(REQ_SEGMENT, 13, 4, 4, 0, 0, 10, 0, 0));
		// zero-length segment acts as its start point
		queue_query(mk_query(REQ_SEGMENT, 7, 7, 0, 7, 7, 7, 7, 0));
		queue_query(mk_query(REQ_SEGMENT, 10, 11, 5, 7, 7, 7, 7, 0));
		queue_query(mk_query(REQ_SEGMENT, 10, 11, 4, 7, 7, 7, 7, 0));
		// zero-radius query on and off a diagonal segment
		queue_query(mk_query(REQ_SEGMENT, 2, 2, 0, 0, 0, 4, 4, 0));
		queue_query(mk_query(REQ_SEGMENT, 2, 3, 0, 0, 0, 4, 4, 0));
		// projection exactly at the start of a reversed segment
		queue_query(mk_query(REQ_SEGMENT, 10, 5, 5, 10, 0, 0, 0, 0));
		// segment extremes
		queue_query(mk_query(REQ_SEGMENT, 32767, -32768, 32767,
		                     -32768, -32768, 32767, 32767, 0));
		queue_query(mk_query(REQ_SEGMENT, -32768, 32767, 0,
		                     -32768, -32768, 32767, 32767, 32767));
		queue_query(mk_query(REQ_SEGMENT, -32768, -32768, 0,
		                     -32768, -32768, -32768, -32768, 0));
		wait_results();

		run_phase(300, 0, 0);
		run_phase(300, 64, 0);
		run_phase(300, 0, 64);
		run_phase(300, 37, 37);

		// sink held off while the source keeps offering: pipeline fills and stalls
		@(negedge clk);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		sink_hold     = 1'b1;
		for (i = 0; i < 150; i++)
			queue_query(random_query());
		repeat (80) @(negedge clk);
		sink_hold = 1'b0;
		wait_results();

		repeat (4 * PIPE_DEPTH) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("PASS circle_shape_overlap_test_unit");
		else
			$display("FAIL circle_shape_overlap_test_unit");
		$finish;
	end

endmodule : tb_circle_shape_overlap_test_unit
